// ===== sv/sfs_pkg.sv =====
`timescale 1ns / 1ps

package sfs_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SUB,
    S_ADV,
    S_PREP,
    S_DIV1,
    S_FIX,
    S_DIV2,
    S_MULX,
    S_MULY,
    S_DONE
  } state_t;

  // Command codes
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAY = 2'd1,
    CMD_STOP = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Register indexes
  localparam logic [2:0] CFG_FRAME_TIME   = 3'd0;
  localparam logic [2:0] CFG_BEGIN_FRAME  = 3'd1;
  localparam logic [2:0] CFG_END_FRAME    = 3'd2;
  localparam logic [2:0] CFG_LOOPING      = 3'd3;
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd5;
  localparam logic [2:0] CFG_MARGIN_X     = 3'd6;
  localparam logic [2:0] CFG_MARGIN_Y     = 3'd7;

  localparam int unsigned TlW  = 26;
  localparam int unsigned DivW = 16;

endpackage

// ===== sv/sprite_frame_sequencer.sv =====
`timescale 1ns / 1ps

// Sprite sheet animation sequencer. Each input transaction (tick, play or stop)
// updates the time-left counter, the current frame and the playing flag, then
// returns the current frame with its top-left pixel in the sheet. One shared
// 16-step restoring divider computes frames per row and then the row/column of
// the frame, and one shared 16x16 multiplier forms both coordinates. The next
// transaction is taken the cycle after the result is loaded into the output
// register, so one transaction is processed at a time. The input is taken
// while an earlier result still waits on a stalled output.
module sprite_frame_sequencer #(
  parameter int SHEET_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [19:0] in_delta_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_frame_index,
  output logic [15:0] out_src_x,
  output logic [15:0] out_src_y,
  output logic        out_is_playing,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam logic [sfs_pkg::DivW-1:0] SheetW = sfs_pkg::DivW'(SHEET_WIDTH);

  sfs_pkg::state_t state_r, state_nxt;

  // Configuration
  logic [23:0] frame_time_r;
  logic [15:0] begin_frame_r;
  logic [15:0] end_frame_r;
  logic        looping_r;
  logic [11:0] frame_width_r;
  logic [11:0] frame_height_r;
  logic [11:0] margin_x_r;
  logic [11:0] margin_y_r;

  // Animation state
  logic signed [sfs_pkg::TlW-1:0] time_left_r;
  logic signed [sfs_pkg::TlW:0]   t_r;
  logic [15:0] frame_r;
  logic        playing_r;
  logic [19:0] delta_r;

  // Shared divider
  logic [sfs_pkg::DivW-1:0] div_num_r;
  logic [sfs_pkg::DivW-1:0] div_den_r;
  logic [sfs_pkg::DivW-1:0] div_rem_r;
  logic [3:0]               div_cnt_r;
  logic [sfs_pkg::DivW:0]   div_sh;
  logic                     div_ge;
  logic [sfs_pkg::DivW-1:0] div_rem_nxt;

  // Shared multiplier
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;

  // Results
  logic [15:0] res_x_r, res_y_r;
  logic [15:0] out_frame_r, out_x_r, out_y_r;
  logic        out_play_r, out_valid_r;

  logic [12:0] pitch_x, pitch_y;
  logic [15:0] per_row;
  logic        in_accept;
  logic        tick_play;
  logic        next_gt;
  logic [16:0] next_frame;
  logic signed [sfs_pkg::TlW:0] t_add;
  logic signed [sfs_pkg::TlW:0] t_sat;
  logic        t_le0;

  assign in_stall  = (state_r != sfs_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign tick_play = (sfs_pkg::cmd_t'(in_command) == sfs_pkg::CMD_TICK) && playing_r;

  assign pitch_x = {1'b0, frame_width_r} + {1'b0, margin_x_r};
  assign pitch_y = {1'b0, frame_height_r} + {1'b0, margin_y_r};
  assign per_row = ((pitch_x == '0) || (div_num_r == '0)) ? 16'd1 : div_num_r;

  // Divider step
  assign div_sh      = {div_rem_r, div_num_r[sfs_pkg::DivW-1]};
  assign div_ge      = (div_sh >= {1'b0, div_den_r});
  assign div_rem_nxt = div_ge ? sfs_pkg::DivW'(div_sh - {1'b0, div_den_r})
                              : div_sh[sfs_pkg::DivW-1:0];

  // Multiplier operands: remainder by pitch_x, then quotient by pitch_y
  assign mul_a = (state_r == sfs_pkg::S_MULX) ? div_rem_r : div_num_r;
  assign mul_b = (state_r == sfs_pkg::S_MULX) ? {3'b0, pitch_x} : {3'b0, pitch_y};
  assign mul_p = mul_a * mul_b;

  // Frame advance and time refill
  assign next_frame = {1'b0, frame_r} + 17'd1;
  assign next_gt    = (next_frame > {1'b0, end_frame_r});
  assign t_le0      = t_r[sfs_pkg::TlW] || (t_r == '0);
  assign t_add      = t_le0 ? (t_r + $signed({3'b0, frame_time_r})) : t_r;

  // Saturate to the 26-bit signed range
  always_comb begin
    if (t_add[sfs_pkg::TlW] != t_add[sfs_pkg::TlW-1]) begin
      t_sat = t_add[sfs_pkg::TlW] ? {2'b11, {(sfs_pkg::TlW-1){1'b0}}}
                                  : {2'b00, {(sfs_pkg::TlW-1){1'b1}}};
    end else begin
      t_sat = t_add;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfs_pkg::S_IDLE: begin
        if (in_accept) state_nxt = tick_play ? sfs_pkg::S_SUB : sfs_pkg::S_PREP;
      end
      sfs_pkg::S_SUB:  state_nxt = sfs_pkg::S_ADV;
      sfs_pkg::S_ADV:  state_nxt = sfs_pkg::S_PREP;
      sfs_pkg::S_PREP: state_nxt = sfs_pkg::S_DIV1;
      sfs_pkg::S_DIV1: begin
        if (div_cnt_r == '1) state_nxt = sfs_pkg::S_FIX;
      end
      sfs_pkg::S_FIX:  state_nxt = sfs_pkg::S_DIV2;
      sfs_pkg::S_DIV2: begin
        if (div_cnt_r == '1) state_nxt = sfs_pkg::S_MULX;
      end
      sfs_pkg::S_MULX: state_nxt = sfs_pkg::S_MULY;
      sfs_pkg::S_MULY: state_nxt = sfs_pkg::S_DONE;
      sfs_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = sfs_pkg::S_IDLE;
      end
      default:         state_nxt = sfs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sfs_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Configuration registers and animation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_time_r   <= '0;
      begin_frame_r  <= '0;
      end_frame_r    <= '0;
      looping_r      <= 1'b1;
      frame_width_r  <= 12'd1;
      frame_height_r <= 12'd1;
      margin_x_r     <= '0;
      margin_y_r     <= '0;
      time_left_r    <= '0;
      frame_r        <= '0;
      playing_r      <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          sfs_pkg::CFG_FRAME_TIME:   frame_time_r <= cfg_wdata;
          sfs_pkg::CFG_BEGIN_FRAME: begin
            begin_frame_r <= cfg_wdata[15:0];
            frame_r       <= cfg_wdata[15:0];
          end
          sfs_pkg::CFG_END_FRAME:    end_frame_r    <= cfg_wdata[15:0];
          sfs_pkg::CFG_LOOPING:      looping_r      <= cfg_wdata[0];
          sfs_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[11:0];
          sfs_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[11:0];
          sfs_pkg::CFG_MARGIN_X:     margin_x_r     <= cfg_wdata[11:0];
          sfs_pkg::CFG_MARGIN_Y:     margin_y_r     <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      // Apply play and stop at accept
      if (in_accept) begin
        case (sfs_pkg::cmd_t'(in_command))
          sfs_pkg::CMD_PLAY: playing_r <= 1'b1;
          sfs_pkg::CMD_STOP: playing_r <= 1'b0;
          default: ;
        endcase
      end
      // Refill time and advance the frame
      if (state_r == sfs_pkg::S_ADV) begin
        time_left_r <= t_sat[sfs_pkg::TlW-1:0];
        if (t_le0) begin
          if (!next_gt) begin
            frame_r <= next_frame[15:0];
          end else if (looping_r) begin
            frame_r <= begin_frame_r;
          end else begin
            playing_r <= 1'b0;
          end
        end
      end
    end
  end

  // Datapath: subtract, divide, multiply
  always_ff @(posedge clk) begin
    if (in_accept) delta_r <= in_delta_us;
    if (state_r == sfs_pkg::S_SUB) begin
      t_r <= $signed({time_left_r[sfs_pkg::TlW-1], time_left_r}) - $signed({7'b0, delta_r});
    end
    case (state_r)
      sfs_pkg::S_PREP: begin
        div_num_r <= SheetW;
        div_den_r <= {3'b0, pitch_x};
        div_rem_r <= '0;
        div_cnt_r <= '0;
      end
      sfs_pkg::S_FIX: begin
        div_num_r <= frame_r;
        div_den_r <= per_row;
        div_rem_r <= '0;
        div_cnt_r <= '0;
      end
      sfs_pkg::S_DIV1, sfs_pkg::S_DIV2: begin
        div_num_r <= {div_num_r[sfs_pkg::DivW-2:0], div_ge};
        div_rem_r <= div_rem_nxt;
        div_cnt_r <= div_cnt_r + 4'd1;
      end
      sfs_pkg::S_MULX: res_x_r <= mul_p[15:0] + {4'b0, margin_x_r};
      sfs_pkg::S_MULY: res_y_r <= mul_p[15:0] + {4'b0, margin_y_r};
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sfs_pkg::S_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sfs_pkg::S_DONE && (!out_valid_r || !out_stall)) begin
      out_frame_r <= frame_r;
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_play_r  <= playing_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_index = out_frame_r;
  assign out_src_x       = out_x_r;
  assign out_src_y       = out_y_r;
  assign out_is_playing  = out_play_r;

  // Second division starts only after a full first run
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sfs_pkg::S_FIX) |-> ($past(state_r) == sfs_pkg::S_DIV1 && $past(div_cnt_r) == '1))
    else $error("divider run cut short");

  // Frames per row is never zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sfs_pkg::S_DIV2) |-> (div_den_r != '0))
    else $error("zero divisor for frame row");

  // A result is loaded only from the final sequencer step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == sfs_pkg::S_DONE))
    else $error("result loaded outside done step");

  // Playing stops only on a stop command or at the end of a non-looping run
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(playing_r) |-> ($past(state_r) == sfs_pkg::S_ADV
      || ($past(in_accept) && $past(in_command) == sfs_pkg::CMD_STOP)))
    else $error("playing flag cleared unexpectedly");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int SheetWidth = 1024;
  localparam int WatchLimit = 4000;
  localparam int PhaseItems = 240;
  localparam int PhaseCount = 8;
  localparam logic [19:0] DeltaMax = 20'hFFFFF;
  localparam longint TimeLeftMin = -(longint'(1) << (sfs_pkg::TlW - 1));
  localparam longint TimeLeftMax = (longint'(1) << (sfs_pkg::TlW - 1)) - 1;

  typedef struct packed {
    logic [15:0] frame_index;
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic        is_playing;
  } frame_view_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [2:0]    cfg_idx;
    logic [23:0]   cfg_val;
    sfs_pkg::cmd_t cmd;
    logic [19:0]   delta;
    logic          checked;
    frame_view_t   view;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [19:0] in_delta_us;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_frame_index;
  logic [15:0] out_src_x;
  logic [15:0] out_src_y;
  logic        out_is_playing;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;

  // Typed expectation riding along with the current input transaction
  logic        row_checked;
  frame_view_t row_view;

  // Register and state mirror of the sequencer
  logic [23:0] frame_time_r;
  logic [15:0] begin_r;
  logic [15:0] end_r;
  logic        loop_r;
  logic [11:0] fw_r;
  logic [11:0] fh_r;
  logic [11:0] mx_r;
  logic [11:0] my_r;
  longint      time_left_r;
  logic [15:0] frame_r;
  logic        playing_r;

  frame_view_t expected_frames[$];
  dir_row_t    dir_rows[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;

  sprite_frame_sequencer #(
    .SHEET_WIDTH(SheetWidth)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_delta_us(in_delta_us),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_frame_index(out_frame_index),
    .out_src_x(out_src_x),
    .out_src_y(out_src_y),
    .out_is_playing(out_is_playing),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance the mirrored animation by one command and return the frame view
  function automatic frame_view_t predict_frame(sfs_pkg::cmd_t cmd, logic [19:0] delta);
    longint t, d, ft, fw, fh, mx, my, px, py, per_row, fr, x, y;
    int unsigned nxt;
    frame_view_t v;
    d  = delta;
    ft = frame_time_r;
    case (cmd)
      sfs_pkg::CMD_TICK: begin
        if (playing_r) begin
          t = time_left_r - d;
          if (t <= 0) begin
            t = t + ft;
            nxt = frame_r;
            nxt = nxt + 1;
            if (nxt > end_r) begin
              if (loop_r) begin
                nxt = begin_r;
              end else begin
                playing_r = 1'b0;
                nxt = frame_r;
              end
            end
            frame_r = nxt[15:0];
          end
          if (t < TimeLeftMin) t = TimeLeftMin;
          if (t > TimeLeftMax) t = TimeLeftMax;
          time_left_r = t;
        end
      end
      sfs_pkg::CMD_PLAY: playing_r = 1'b1;
      sfs_pkg::CMD_STOP: playing_r = 1'b0;
      default: ;
    endcase
    // Sheet position: a zero pitch or a pitch wider than the sheet gives one per row
    fw = fw_r;
    fh = fh_r;
    mx = mx_r;
    my = my_r;
    px = fw + mx;
    py = fh + my;
    per_row = (px != 0) ? SheetWidth / px : 1;
    if (per_row == 0) per_row = 1;
    fr = frame_r;
    x = (fr % per_row) * px + mx;
    y = (fr / per_row) * py + my;
    v.frame_index = frame_r;
    v.src_x       = x[15:0];
    v.src_y       = y[15:0];
    v.is_playing  = playing_r;
    return v;
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [23:0] data);
    case (idx)
      sfs_pkg::CFG_FRAME_TIME:   frame_time_r = data;
      sfs_pkg::CFG_BEGIN_FRAME: begin
        begin_r = data[15:0];
        frame_r = data[15:0];
      end
      sfs_pkg::CFG_END_FRAME:    end_r = data[15:0];
      sfs_pkg::CFG_LOOPING:      loop_r = data[0];
      sfs_pkg::CFG_FRAME_WIDTH:  fw_r = data[11:0];
      sfs_pkg::CFG_FRAME_HEIGHT: fh_r = data[11:0];
      sfs_pkg::CFG_MARGIN_X:     mx_r = data[11:0];
      sfs_pkg::CFG_MARGIN_Y:     my_r = data[11:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Track config writes, predict accepted inputs and check accepted results
  always @(posedge clk) begin : monitor
    frame_view_t want;
    frame_view_t got;
    if (!rst_n) begin
      frame_time_r = '0;
      begin_r      = '0;
      end_r        = '0;
      loop_r       = 1'b1;
      fw_r         = 12'd1;
      fh_r         = 12'd1;
      mx_r         = '0;
      my_r         = '0;
      time_left_r  = 0;
      frame_r      = '0;
      playing_r    = 1'b1;
      expected_frames.delete();
    end else begin
      if (cfg_wr_en) apply_register(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) begin
        want = predict_frame(sfs_pkg::cmd_t'(in_command), in_delta_us);
        if (row_checked) want = row_view;
        expected_frames.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {out_frame_index, out_src_x, out_src_y, out_is_playing};
        if (expected_frames.size() == 0) begin
          $error("result transaction with no input pending");
          mismatch_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_index", want.frame_index, got.frame_index);
          check_field("src_x", want.src_x, got.src_x);
          check_field("src_y", want.src_y, got.src_y);
          check_field("is_playing", want.is_playing, got.is_playing);
        end
      end
    end
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void add_cfg(logic [2:0] idx, logic [23:0] val);
    dir_row_t r;
    r.kind    = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    r.cmd     = sfs_pkg::CMD_TICK;
    r.delta   = '0;
    r.checked = 1'b0;
    r.view    = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_item(sfs_pkg::cmd_t cmd, logic [19:0] delta, logic checked,
                                   frame_view_t view);
    dir_row_t r;
    r.kind    = ROW_ITEM;
    r.cfg_idx = sfs_pkg::CFG_FRAME_TIME;
    r.cfg_val = '0;
    r.cmd     = cmd;
    r.delta   = delta;
    r.checked = checked;
    r.view    = view;
    dir_rows.push_back(r);
  endfunction

  // Present one input transaction, idling first at the sender rate; hold until taken
  task automatic push_item(sfs_pkg::cmd_t cmd, logic [19:0] delta, logic checked,
                           frame_view_t view);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 50);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_delta_us <= delta;
    row_checked <= checked;
    row_view    <= view;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain the block, then write one register
  task automatic write_register(logic [2:0] idx, logic [23:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One random phase: pick a setting, write every register, then drive commands
  task automatic run_phase(int ph);
    logic [23:0]   ft;
    logic [15:0]   bf, ef;
    logic          lp;
    logic [11:0]   fw, fh, mx, my;
    logic [19:0]   delta;
    sfs_pkg::cmd_t cmd;
    int            dmax, r;
    bit            heavy;
    heavy = 1'b0;
    case (ph % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
      default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
    endcase
    if (ph == 0) begin
      // Zero frame time and big ticks: drive time left into saturation
      ft = '0; bf = '0; ef = 16'd3; lp = 1'b1;
      fw = 12'd1; fh = 12'd1; mx = '0; my = '0;
      heavy = 1'b1;
    end else if (ph == 1) begin
      // Everything at the top of its range, no looping
      ft = 24'hFFFFFF; bf = 16'hFFF0; ef = 16'hFFFF; lp = 1'b0;
      fw = 12'hFFF; fh = 12'hFFF; mx = 12'hFFF; my = 12'hFFF;
    end else begin
      ft = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
      bf = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      ef = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(bf + $urandom_range(0, 24));
      lp = 1'($urandom_range(0, 1));
      fw = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(1, 4095))
                                       : 12'($urandom_range(1, 64));
      fh = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(1, 4095))
                                       : 12'($urandom_range(1, 64));
      mx = ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 8));
      my = ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 8));
    end
    dmax = (ft > 24'd500000) ? int'(DeltaMax) : 2 * int'(ft) + 16;
    write_register(sfs_pkg::CFG_FRAME_TIME, ft);
    write_register(sfs_pkg::CFG_BEGIN_FRAME, {8'd0, bf});
    write_register(sfs_pkg::CFG_END_FRAME, {8'd0, ef});
    write_register(sfs_pkg::CFG_LOOPING, {23'd0, lp});
    write_register(sfs_pkg::CFG_FRAME_WIDTH, {12'd0, fw});
    write_register(sfs_pkg::CFG_FRAME_HEIGHT, {12'd0, fh});
    write_register(sfs_pkg::CFG_MARGIN_X, {12'd0, mx});
    write_register(sfs_pkg::CFG_MARGIN_Y, {12'd0, my});
    for (int i = 0; i < PhaseItems; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) cmd = sfs_pkg::CMD_TICK;
      else if (r < 89) cmd = sfs_pkg::CMD_PLAY;
      else if (r < 95) cmd = sfs_pkg::CMD_STOP;
      else cmd = sfs_pkg::CMD_NONE;
      if (heavy && $urandom_range(0, 3) != 0) delta = DeltaMax;
      else if ($urandom_range(0, 19) == 0) delta = 20'($urandom);
      else delta = 20'($urandom_range(0, dmax));
      push_item(cmd, delta, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_command  <= sfs_pkg::CMD_TICK;
    in_delta_us <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= sfs_pkg::CFG_FRAME_TIME;
    cfg_wdata   <= '0;
    row_checked <= 1'b0;
    row_view    <= '0;

    // Directed table: reset values first
    add_item(sfs_pkg::CMD_TICK, 20'd0, 1'b1, {16'd0, 16'd0, 16'd0, 1'b1});
    add_item(sfs_pkg::CMD_STOP, 20'd0, 1'b1, {16'd0, 16'd0, 16'd0, 1'b0});
    // Tick while stopped changes nothing; the unused command is ignored
    add_item(sfs_pkg::CMD_TICK, DeltaMax, 1'b1, {16'd0, 16'd0, 16'd0, 1'b0});
    add_item(sfs_pkg::CMD_NONE, DeltaMax, 1'b1, {16'd0, 16'd0, 16'd0, 1'b0});
    add_item(sfs_pkg::CMD_PLAY, 20'd0, 1'b1, {16'd0, 16'd0, 16'd0, 1'b1});
    // Top frame with widest pitch: coordinates wrap
    add_cfg(sfs_pkg::CFG_END_FRAME, 24'hFFFF);
    add_cfg(sfs_pkg::CFG_BEGIN_FRAME, 24'hFFFF);
    add_cfg(sfs_pkg::CFG_FRAME_WIDTH, 24'hFFF);
    add_cfg(sfs_pkg::CFG_FRAME_HEIGHT, 24'hFFF);
    add_cfg(sfs_pkg::CFG_MARGIN_X, 24'hFFF);
    add_cfg(sfs_pkg::CFG_MARGIN_Y, 24'hFFF);
    add_item(sfs_pkg::CMD_PLAY, 20'd0, 1'b1, {16'hFFFF, 16'd4095, 16'd61441, 1'b1});
    add_item(sfs_pkg::CMD_TICK, 20'd0, 1'b0, '0);
    // Past the end without looping: stop and hold the frame
    add_cfg(sfs_pkg::CFG_LOOPING, 24'd0);
    add_item(sfs_pkg::CMD_TICK, 20'd1, 1'b0, '0);
    add_item(sfs_pkg::CMD_TICK, 20'h55555, 1'b0, '0);
    // Zero horizontal pitch: one frame per row
    add_cfg(sfs_pkg::CFG_FRAME_WIDTH, 24'd0);
    add_cfg(sfs_pkg::CFG_MARGIN_X, 24'd0);
    add_cfg(sfs_pkg::CFG_FRAME_HEIGHT, 24'd3);
    add_cfg(sfs_pkg::CFG_MARGIN_Y, 24'd2);
    add_cfg(sfs_pkg::CFG_BEGIN_FRAME, 24'd5);
    add_cfg(sfs_pkg::CFG_END_FRAME, 24'd7);
    add_cfg(sfs_pkg::CFG_LOOPING, 24'd1);
    add_cfg(sfs_pkg::CFG_FRAME_TIME, 24'd100);
    add_item(sfs_pkg::CMD_PLAY, 20'd0, 1'b1, {16'd5, 16'd0, 16'd27, 1'b1});
    add_item(sfs_pkg::CMD_TICK, 20'd40, 1'b0, '0);
    add_item(sfs_pkg::CMD_TICK, 20'd40, 1'b0, '0);
    add_item(sfs_pkg::CMD_TICK, 20'd19, 1'b0, '0);
    add_item(sfs_pkg::CMD_TICK, 20'd100, 1'b0, '0);
    add_item(sfs_pkg::CMD_TICK, DeltaMax, 1'b0, '0);
    // Regular grid of 32 per row, long interval
    add_cfg(sfs_pkg::CFG_FRAME_WIDTH, 24'd32);
    add_cfg(sfs_pkg::CFG_FRAME_HEIGHT, 24'd32);
    add_cfg(sfs_pkg::CFG_MARGIN_Y, 24'd0);
    add_cfg(sfs_pkg::CFG_BEGIN_FRAME, 24'd30);
    add_cfg(sfs_pkg::CFG_END_FRAME, 24'hFFFF);
    add_item(sfs_pkg::CMD_TICK, 20'hAAAAA, 1'b0, '0);
    add_item(sfs_pkg::CMD_TICK, 20'd0, 1'b0, '0);
    add_item(sfs_pkg::CMD_TICK, 20'd1, 1'b0, '0);
    add_item(sfs_pkg::CMD_NONE, 20'd0, 1'b0, '0);
    add_item(sfs_pkg::CMD_TICK, 20'd500, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_register(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        push_item(dir_rows[i].cmd, dir_rows[i].delta, dir_rows[i].checked, dir_rows[i].view);
      end
    end

    for (int ph = 0; ph < PhaseCount; ph++) run_phase(ph);

    // Drain, then allow the pipeline latency before judging
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
